// File: design/eed_pkg.sv
package eed_pkg;

    typedef enum logic [3:0] {
        PH_VERSION = 4'd0,
        PH_TYPE    = 4'd1,
        PH_HDR2    = 4'd2,
        PH_HDR3    = 4'd3,
        PH_ERRCODE = 4'd4,
        PH_SEQ     = 4'd5,
        PH_EVENT   = 4'd6,
        PH_SESSLEN = 4'd7,
        PH_SKIP    = 4'd8,
        PH_PAYLEN  = 4'd9,
        PH_PAYLOAD = 4'd10,
        PH_TRAILER = 4'd11,
        PH_DISCARD = 4'd12
    } t_phase;

    localparam logic [7:0] VERSION_BYTE = 8'h11;

    // message type, high nibble of the second header byte
    localparam logic [3:0] TYPE_ERROR = 4'hF;
    localparam logic [3:0] TYPE_JSON  = 4'h9;
    localparam logic [3:0] TYPE_AUDIO = 4'hB;

    localparam logic [1:0] KIND_ERROR = 2'd0;
    localparam logic [1:0] KIND_JSON  = 2'd1;
    localparam logic [1:0] KIND_AUDIO = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_TYPE  = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    localparam logic [3:0] FLAG_SEQ_MASK = 4'h3;
    localparam logic [3:0] FLAG_EVENT    = 4'h4;

    localparam logic [3:0] MIN_FRAME_BYTES = 4'd8;

    typedef struct packed {
        logic [7:0]         payload_byte;
        logic               payload_valid;
        logic               frame_done;
        logic [1:0]         status;
        logic [1:0]         kind;
        logic [31:0]        fault_code;
        logic signed [31:0] sequence_res;
        logic [31:0]        event_id;
        logic [31:0]        payload_length;
    } t_result;

    function automatic t_phase phase_after_seq(input logic [3:0] flags);
        return ((flags & FLAG_EVENT) != 4'h0) ? PH_EVENT : PH_PAYLEN;
    endfunction

    function automatic t_phase phase_after_error(input logic [3:0] flags);
        return ((flags & FLAG_SEQ_MASK) != 4'h0) ? PH_SEQ : phase_after_seq(flags);
    endfunction

endpackage

// File: design/eed_parse.sv
module eed_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_frame_last,
    output logic                 o_present,
    output eed_pkg::t_result     o_result
);

    eed_pkg::t_phase r_phase, s_phase, n_phase;
    logic [1:0]  r_idx, s_idx, n_idx;
    logic [31:0] r_shift, s_shift, n_shift;
    logic [3:0]  r_cnt, s_cnt, n_cnt;
    logic [3:0]  r_flags, s_flags, n_flags;
    logic [1:0]  r_kind, s_kind, n_kind;
    logic [1:0]  r_fstat, s_fstat, n_fstat;
    logic [31:0] r_err, s_err, n_err;
    logic [31:0] r_seq, s_seq, n_seq;
    logic [31:0] r_evt, s_evt, n_evt;
    logic [31:0] r_skip, s_skip, n_skip;
    logic [31:0] r_decl, s_decl, n_decl;
    logic [31:0] r_left, s_left, n_left;
    logic [31:0] word;
    logic        pay_hit;
    logic [1:0]  status;

    assign word = {r_shift[23:0], i_data_byte};

    // next state of one step, before the frame-end clear
    always_comb begin
        s_phase = r_phase;
        s_idx   = r_idx;
        s_shift = r_shift;
        s_cnt   = (r_cnt != 4'hF) ? r_cnt + 4'd1 : r_cnt;
        s_flags = r_flags;
        s_kind  = r_kind;
        s_fstat = r_fstat;
        s_err   = r_err;
        s_seq   = r_seq;
        s_evt   = r_evt;
        s_skip  = r_skip;
        s_decl  = r_decl;
        s_left  = r_left;
        pay_hit = 1'b0;
        case (r_phase)
            eed_pkg::PH_VERSION: begin
                if (i_data_byte != eed_pkg::VERSION_BYTE) begin
                    s_fstat = eed_pkg::ST_SHORT;
                    s_phase = eed_pkg::PH_DISCARD;
                end else begin
                    s_phase = eed_pkg::PH_TYPE;
                end
            end
            eed_pkg::PH_TYPE: begin
                s_flags = i_data_byte[3:0];
                s_phase = eed_pkg::PH_HDR2;
                case (i_data_byte[7:4])
                    eed_pkg::TYPE_ERROR: s_kind = eed_pkg::KIND_ERROR;
                    eed_pkg::TYPE_JSON:  s_kind = eed_pkg::KIND_JSON;
                    eed_pkg::TYPE_AUDIO: s_kind = eed_pkg::KIND_AUDIO;
                    default: begin
                        s_fstat = eed_pkg::ST_TYPE;
                        s_phase = eed_pkg::PH_DISCARD;
                    end
                endcase
            end
            eed_pkg::PH_HDR2: s_phase = eed_pkg::PH_HDR3;
            eed_pkg::PH_HDR3: begin
                s_phase = (r_kind == eed_pkg::KIND_ERROR) ? eed_pkg::PH_ERRCODE
                                                          : eed_pkg::phase_after_error(r_flags);
            end
            eed_pkg::PH_ERRCODE, eed_pkg::PH_SEQ, eed_pkg::PH_EVENT,
            eed_pkg::PH_SESSLEN, eed_pkg::PH_PAYLEN: begin
                if (r_idx == 2'd3) begin
                    s_idx   = 2'd0;
                    s_shift = 32'd0;
                    case (r_phase)
                        eed_pkg::PH_ERRCODE: begin
                            s_err   = word;
                            s_phase = eed_pkg::phase_after_error(r_flags);
                        end
                        eed_pkg::PH_SEQ: begin
                            s_seq   = word;
                            s_phase = eed_pkg::phase_after_seq(r_flags);
                        end
                        eed_pkg::PH_EVENT: begin
                            s_evt   = word;
                            s_phase = eed_pkg::PH_SESSLEN;
                        end
                        eed_pkg::PH_SESSLEN: begin
                            s_skip  = word;
                            s_phase = (word != 32'd0) ? eed_pkg::PH_SKIP
                                                      : eed_pkg::PH_PAYLEN;
                        end
                        default: begin
                            s_decl  = word;
                            s_left  = word;
                            s_phase = (word != 32'd0) ? eed_pkg::PH_PAYLOAD
                                                      : eed_pkg::PH_TRAILER;
                        end
                    endcase
                end else begin
                    s_idx   = r_idx + 2'd1;
                    s_shift = word;
                end
            end
            eed_pkg::PH_SKIP: begin
                s_skip = r_skip - 32'd1;
                if (r_skip == 32'd1) begin
                    s_phase = eed_pkg::PH_PAYLEN;
                end
            end
            eed_pkg::PH_PAYLOAD: begin
                pay_hit = 1'b1;
                s_left  = r_left - 32'd1;
                if (r_left == 32'd1) begin
                    s_phase = eed_pkg::PH_TRAILER;
                end
            end
            default: ;
        endcase
    end

    // frame end returns everything to the reset values
    always_comb begin
        if (i_frame_last) begin
            n_phase = eed_pkg::PH_VERSION;
            n_idx   = 2'd0;
            n_shift = 32'd0;
            n_cnt   = 4'd0;
            n_flags = 4'd0;
            n_kind  = eed_pkg::KIND_ERROR;
            n_fstat = eed_pkg::ST_OK;
            n_err   = 32'd0;
            n_seq   = 32'd0;
            n_evt   = 32'd0;
            n_skip  = 32'd0;
            n_decl  = 32'd0;
            n_left  = 32'd0;
        end else begin
            n_phase = s_phase;
            n_idx   = s_idx;
            n_shift = s_shift;
            n_cnt   = s_cnt;
            n_flags = s_flags;
            n_kind  = s_kind;
            n_fstat = s_fstat;
            n_err   = s_err;
            n_seq   = s_seq;
            n_evt   = s_evt;
            n_skip  = s_skip;
            n_decl  = s_decl;
            n_left  = s_left;
        end
    end

    // result of the step
    always_comb begin
        if (s_cnt < eed_pkg::MIN_FRAME_BYTES) begin
            status = eed_pkg::ST_SHORT;
        end else if (s_fstat != eed_pkg::ST_OK) begin
            status = s_fstat;
        end else if (s_phase != eed_pkg::PH_TRAILER) begin
            status = eed_pkg::ST_TRUNC;
        end else begin
            status = eed_pkg::ST_OK;
        end
        o_present = pay_hit || i_frame_last;
        o_result  = '0;
        o_result.payload_valid = pay_hit;
        o_result.payload_byte  = pay_hit ? i_data_byte : 8'd0;
        if (i_frame_last) begin
            o_result.frame_done = 1'b1;
            o_result.status     = status;
            if (status == eed_pkg::ST_OK) begin
                o_result.kind           = s_kind;
                o_result.fault_code     = s_err;
                o_result.sequence_res   = s_seq;
                o_result.event_id       = s_evt;
                o_result.payload_length = s_decl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= eed_pkg::PH_VERSION;
            r_idx   <= 2'd0;
            r_shift <= 32'd0;
            r_cnt   <= 4'd0;
            r_flags <= 4'd0;
            r_kind  <= eed_pkg::KIND_ERROR;
            r_fstat <= eed_pkg::ST_OK;
            r_err   <= 32'd0;
            r_seq   <= 32'd0;
            r_evt   <= 32'd0;
            r_skip  <= 32'd0;
            r_decl  <= 32'd0;
            r_left  <= 32'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_cnt   <= n_cnt;
            r_flags <= n_flags;
            r_kind  <= n_kind;
            r_fstat <= n_fstat;
            r_err   <= n_err;
            r_seq   <= n_seq;
            r_evt   <= n_evt;
            r_skip  <= n_skip;
            r_decl  <= n_decl;
            r_left  <= n_left;
        end
    end

endmodule

// File: design/event_envelope_deframer.sv
// Byte-serial deframer for a length-prefixed binary event envelope.
// Input channel (i_in_valid / o_in_ready) carries one frame byte per item,
// with i_frame_last on the final byte. Output channel (o_out_valid /
// i_out_ready) carries a result only for payload bytes inside the declared
// length and for the last byte of a frame; other bytes update the parser and
// produce nothing.
// On frame end the result has o_frame_done set with status, kind, fault code,
// sequence, event id and payload length; these read zero unless status is ok.
// A result is registered and shows on the outputs in the cycle after its byte is taken.
// Throughput: one byte per cycle while the receiver does not stall; the parser state
// and the single output register both turn over every cycle.
// When the receiver stalls, the result waits in the output register and the
// input keeps taking bytes as long as they produce no result; a byte that
// would produce one waits until the register is taken or empty.
// Reset (i_rst_n low, synchronous) returns the parser to expecting the
// version byte and drops any pending result.
module event_envelope_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_payload_byte,
    output logic               o_payload_valid,
    output logic               o_frame_done,
    output logic [1:0]         o_status,
    output logic [1:0]         o_kind,
    output logic [31:0]        o_fault_code,
    output logic signed [31:0] o_sequence_res,
    output logic [31:0]        o_event_id,
    output logic [31:0]        o_payload_length
);

    logic             accept;
    logic             present;
    logic             room;
    eed_pkg::t_result result;
    eed_pkg::t_result r_out;
    logic             r_out_valid;

    assign room       = !r_out_valid || i_out_ready;
    assign o_in_ready = room || (i_in_valid && !present);
    assign accept     = i_in_valid && o_in_ready;

    eed_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_frame_last (i_frame_last),
        .o_present    (present),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (room) begin
            r_out_valid <= accept && present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && present && room) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_valid  = r_out.payload_valid;
    assign o_frame_done     = r_out.frame_done;
    assign o_status         = r_out.status;
    assign o_kind           = r_out.kind;
    assign o_fault_code     = r_out.fault_code;
    assign o_sequence_res   = r_out.sequence_res;
    assign o_event_id       = r_out.event_id;
    assign o_payload_length = r_out.payload_length;

endmodule

// File: design/eed_checker.sv
module eed_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [7:0]         o_payload_byte,
    input logic               o_payload_valid,
    input logic               o_frame_done,
    input logic [1:0]         o_status,
    input logic [1:0]         o_kind,
    input logic [31:0]        o_fault_code,
    input logic signed [31:0] o_sequence_res,
    input logic [31:0]        o_event_id,
    input logic [31:0]        o_payload_length
);

    // an empty output stage never holds off the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_payload_byte)
            && $stable(o_frame_done) && $stable(o_status) && $stable(o_payload_length))
        else $error("stalled item changed");

    a_no_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_payload_valid || o_frame_done)
        else $error("item carries neither payload nor frame end");

    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_done |-> o_status == eed_pkg::ST_OK
            && o_payload_length == 32'd0 && o_event_id == 32'd0)
        else $error("summary fields set outside frame end");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != eed_pkg::ST_OK |-> o_kind == eed_pkg::KIND_ERROR
            && o_fault_code == 32'd0 && o_sequence_res == 32'sd0
            && o_payload_length == 32'd0)
        else $error("failed frame reports captured fields");

endmodule

bind event_envelope_deframer eed_checker u_eed_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_payload_byte   (o_payload_byte),
    .o_payload_valid  (o_payload_valid),
    .o_frame_done     (o_frame_done),
    .o_status         (o_status),
    .o_kind           (o_kind),
    .o_fault_code     (o_fault_code),
    .o_sequence_res   (o_sequence_res),
    .o_event_id       (o_event_id),
    .o_payload_length (o_payload_length)
);

// File: test/event_envelope_deframer_tb.sv
`timescale 1ns / 1ps

module event_envelope_deframer_tb;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_data_byte = 8'h00;
    logic               i_frame_last = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [7:0]         o_payload_byte;
    logic               o_payload_valid;
    logic               o_frame_done;
    logic [1:0]         o_status;
    logic [1:0]         o_kind;
    logic [31:0]        o_fault_code;
    logic signed [31:0] o_sequence_res;
    logic [31:0]        o_event_id;
    logic [31:0]        o_payload_length;

    event_envelope_deframer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_frame_last     (i_frame_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_payload_byte   (o_payload_byte),
        .o_payload_valid  (o_payload_valid),
        .o_frame_done     (o_frame_done),
        .o_status         (o_status),
        .o_kind           (o_kind),
        .o_fault_code     (o_fault_code),
        .o_sequence_res   (o_sequence_res),
        .o_event_id       (o_event_id),
        .o_payload_length (o_payload_length)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_frame_byte       pending_bytes[$];
    eed_pkg::t_result  predicted_results[$];
    logic [7:0]        frame_buf[$];
    int                mismatch_cnt = 0;
    int                results_seen = 0;
    int                send_gap = 0;
    int                hold_left = 0;
    bit                long_hold_done = 1'b0;
    logic [31:0]       cyc = 32'd0;
    logic              quiet;

    // stretches with no idling on either side
    assign quiet = (cyc[10:9] == 2'd0);

    always @(posedge i_clk) begin
        cyc <= cyc + 32'd1;
    end

    // ---------------- parser prediction ----------------
    eed_pkg::t_phase p_phase;
    logic [1:0]   p_word_idx;
    logic [31:0]  p_word_acc;
    logic [3:0]   p_seen;
    logic [3:0]   p_flags;
    logic [1:0]   p_kind;
    logic [1:0]   p_status;
    logic [31:0]  p_err;
    logic [31:0]  p_seq;
    logic [31:0]  p_evt;
    logic [31:0]  p_skip;
    logic [31:0]  p_pay_decl;
    logic [31:0]  p_pay_left;

    function automatic eed_pkg::t_phase after_seq_phase(input logic [3:0] f);
        return f[2] ? eed_pkg::PH_EVENT : eed_pkg::PH_PAYLEN;
    endfunction

    function automatic eed_pkg::t_phase after_err_phase(input logic [3:0] f);
        return (f[1:0] != 2'b00) ? eed_pkg::PH_SEQ : after_seq_phase(f);
    endfunction

    task automatic clear_parser();
        p_phase    = eed_pkg::PH_VERSION;
        p_word_idx = 2'd0;
        p_word_acc = 32'd0;
        p_seen     = 4'd0;
        p_flags    = 4'd0;
        p_kind     = eed_pkg::KIND_ERROR;
        p_status   = eed_pkg::ST_OK;
        p_err      = 32'd0;
        p_seq      = 32'd0;
        p_evt      = 32'd0;
        p_skip     = 32'd0;
        p_pay_decl = 32'd0;
        p_pay_left = 32'd0;
    endtask

    task automatic deframe_predict(input logic [7:0] b, input logic last);
        eed_pkg::t_result r;
        logic [31:0]      w;
        logic [1:0]       st;
        bit               emit;
        r    = '0;
        emit = 1'b0;
        if (p_seen != 4'd15)
            p_seen = p_seen + 4'd1;
        case (p_phase)
            eed_pkg::PH_VERSION: begin
                if (b != eed_pkg::VERSION_BYTE) begin
                    p_status = eed_pkg::ST_SHORT;
                    p_phase  = eed_pkg::PH_DISCARD;
                end else begin
                    p_phase = eed_pkg::PH_TYPE;
                end
            end
            eed_pkg::PH_TYPE: begin
                p_flags = b[3:0];
                p_phase = eed_pkg::PH_HDR2;
                if (b[7:4] == eed_pkg::TYPE_ERROR) begin
                    p_kind = eed_pkg::KIND_ERROR;
                end else if (b[7:4] == eed_pkg::TYPE_JSON) begin
                    p_kind = eed_pkg::KIND_JSON;
                end else if (b[7:4] == eed_pkg::TYPE_AUDIO) begin
                    p_kind = eed_pkg::KIND_AUDIO;
                end else begin
                    p_status = eed_pkg::ST_TYPE;
                    p_phase  = eed_pkg::PH_DISCARD;
                end
            end
            eed_pkg::PH_HDR2: p_phase = eed_pkg::PH_HDR3;
            eed_pkg::PH_HDR3: begin
                p_phase = (p_kind == eed_pkg::KIND_ERROR) ? eed_pkg::PH_ERRCODE
                                                          : after_err_phase(p_flags);
            end
            eed_pkg::PH_ERRCODE, eed_pkg::PH_SEQ, eed_pkg::PH_EVENT,
            eed_pkg::PH_SESSLEN, eed_pkg::PH_PAYLEN: begin
                w = {p_word_acc[23:0], b};
                if (p_word_idx == 2'd3) begin
                    p_word_idx = 2'd0;
                    p_word_acc = 32'd0;
                    case (p_phase)
                        eed_pkg::PH_ERRCODE: begin
                            p_err   = w;
                            p_phase = after_err_phase(p_flags);
                        end
                        eed_pkg::PH_SEQ: begin
                            p_seq   = w;
                            p_phase = after_seq_phase(p_flags);
                        end
                        eed_pkg::PH_EVENT: begin
                            p_evt   = w;
                            p_phase = eed_pkg::PH_SESSLEN;
                        end
                        eed_pkg::PH_SESSLEN: begin
                            p_skip  = w;
                            p_phase = (w != 32'd0) ? eed_pkg::PH_SKIP : eed_pkg::PH_PAYLEN;
                        end
                        default: begin
                            p_pay_decl = w;
                            p_pay_left = w;
                            p_phase    = (w != 32'd0) ? eed_pkg::PH_PAYLOAD
                                                      : eed_pkg::PH_TRAILER;
                        end
                    endcase
                end else begin
                    p_word_idx = p_word_idx + 2'd1;
                    p_word_acc = w;
                end
            end
            eed_pkg::PH_SKIP: begin
                p_skip = p_skip - 32'd1;
                if (p_skip == 32'd0)
                    p_phase = eed_pkg::PH_PAYLEN;
            end
            eed_pkg::PH_PAYLOAD: begin
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                emit            = 1'b1;
                p_pay_left      = p_pay_left - 32'd1;
                if (p_pay_left == 32'd0)
                    p_phase = eed_pkg::PH_TRAILER;
            end
            default: ;
        endcase

        if (last) begin
            if (p_seen < eed_pkg::MIN_FRAME_BYTES)
                st = eed_pkg::ST_SHORT;
            else if (p_status != eed_pkg::ST_OK)
                st = p_status;
            else if (p_phase != eed_pkg::PH_TRAILER)
                st = eed_pkg::ST_TRUNC;
            else
                st = eed_pkg::ST_OK;
            r.frame_done = 1'b1;
            r.status     = st;
            if (st == eed_pkg::ST_OK) begin
                r.kind           = p_kind;
                r.fault_code     = p_err;
                r.sequence_res   = p_seq;
                r.event_id       = p_evt;
                r.payload_length = p_pay_decl;
            end
            emit = 1'b1;
            clear_parser();
        end
        if (emit)
            predicted_results.push_back(r);
    endtask

    // ---------------- frame building ----------------
    task automatic add_word(input logic [31:0] w);
        frame_buf.push_back(w[31:24]);
        frame_buf.push_back(w[23:16]);
        frame_buf.push_back(w[15:8]);
        frame_buf.push_back(w[7:0]);
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++)
            frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // header and fields in order; session and payload counts may differ
    // from the declared words to produce truncated frames
    task automatic build_frame(input logic [3:0] type_nib, input logic [3:0] flags,
                               input logic [31:0] sess_word, input int sess_cnt,
                               input logic [31:0] pay_word, input int pay_cnt,
                               input int trail);
        frame_buf.delete();
        frame_buf.push_back(eed_pkg::VERSION_BYTE);
        frame_buf.push_back({type_nib, flags});
        add_random(2);
        if (type_nib == eed_pkg::TYPE_ERROR)
            add_word($urandom);
        if (flags[1:0] != 2'b00)
            add_word($urandom);
        if (flags[2]) begin
            add_word($urandom);
            add_word(sess_word);
            add_random(sess_cnt);
        end
        add_word(pay_word);
        add_random(pay_cnt + trail);
    endtask

    task automatic queue_frame(input int keep);
        t_frame_byte fb;
        if (keep <= 0 || keep > frame_buf.size())
            keep = frame_buf.size();
        for (int i = 0; i < keep; i++) begin
            fb.data = frame_buf[i];
            fb.last = (i == keep - 1);
            pending_bytes.push_back(fb);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic string fmt_result(input eed_pkg::t_result r);
        return $sformatf({"pb=%02h pv=%0b done=%0b st=%0d kind=%0d ",
                          "err=%08h seq=%08h evt=%08h len=%08h"},
                         r.payload_byte, r.payload_valid, r.frame_done, r.status, r.kind,
                         r.fault_code, r.sequence_res, r.event_id, r.payload_length);
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        t_frame_byte nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                deframe_predict(i_data_byte, i_frame_last);
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    nxt = pending_bytes.pop_front();
                    i_in_valid   <= 1'b1;
                    i_data_byte  <= nxt.data;
                    i_frame_last <= nxt.last;
                    send_gap = quiet ? 0 : pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ----------------
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            // one long hold-off so the output register fills and input backs up
            if (!long_hold_done && results_seen >= 150) begin
                hold_left      = 400;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (quiet) begin
                i_out_ready <= 1'b1;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    hold_left = stall - 1;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        eed_pkg::t_result got;
        eed_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.payload_byte   = o_payload_byte;
            got.payload_valid  = o_payload_valid;
            got.frame_done     = o_frame_done;
            got.status         = o_status;
            got.kind           = o_kind;
            got.fault_code     = o_fault_code;
            got.sequence_res   = o_sequence_res;
            got.event_id       = o_event_id;
            got.payload_length = o_payload_length;
            results_seen <= results_seen + 1;
            if (predicted_results.size() == 0) begin
                mismatch_cnt = mismatch_cnt + 1;
                if (mismatch_cnt <= 10)
                    $display("%0t: result with none expected: %s", $realtime, fmt_result(got));
            end else begin
                want = predicted_results.pop_front();
                if (got !== want) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= 10) begin
                        $display("%0t: expected %s", $realtime, fmt_result(want));
                        $display("%0t: actual   %s", $realtime, fmt_result(got));
                    end
                end
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        int          pick;
        int          drain;
        logic [3:0]  type_nib;
        logic [3:0]  flags;
        logic [31:0] sess_word;
        logic [31:0] pay_word;
        int          sess_cnt;
        int          pay_cnt;
        int          trail;

        clear_parser();

        // frame of one byte: too short
        frame_buf.delete();
        frame_buf.push_back(eed_pkg::VERSION_BYTE);
        queue_frame(0);
        // bad version, all-zero byte
        frame_buf.delete();
        frame_buf.push_back(8'h00);
        add_random(7);
        queue_frame(0);
        // unknown message type
        frame_buf.delete();
        frame_buf.push_back(eed_pkg::VERSION_BYTE);
        frame_buf.push_back(8'h3F);
        frame_buf.push_back(8'hFF);
        frame_buf.push_back(8'h00);
        add_random(4);
        queue_frame(0);
        // minimal audio frame with one payload byte
        build_frame(eed_pkg::TYPE_AUDIO, 4'h0, 32'd0, 0, 32'd1, 0, 0);
        frame_buf.push_back(8'hFF);
        queue_frame(0);

        while (pending_bytes.size() < 1000) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0:       type_nib = eed_pkg::TYPE_ERROR;
                1:       type_nib = eed_pkg::TYPE_JSON;
                default: type_nib = eed_pkg::TYPE_AUDIO;
            endcase
            flags     = 4'($urandom_range(0, 15));
            sess_cnt  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            sess_word = 32'(sess_cnt);
            pay_cnt   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8)
                                                   : $urandom_range(9, 40);
            pay_word  = 32'(pay_cnt);
            trail     = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 2) : 0;
            if (pick < 70) begin
                build_frame(type_nib, flags, sess_word, sess_cnt, pay_word, pay_cnt, trail);
                queue_frame(0);
            end else if (pick < 85) begin
                build_frame(type_nib, flags, sess_word, sess_cnt, pay_word, pay_cnt, trail);
                queue_frame($urandom_range(1, frame_buf.size()));
            end else if (pick < 90) begin
                // huge declared lengths, frame ends long before them
                if (flags[2] && $urandom_range(0, 1)) begin
                    sess_word = $urandom | 32'h0000_0100;
                    sess_cnt  = $urandom_range(0, 10);
                end else begin
                    pay_word = $urandom | 32'h0000_0100;
                    pay_cnt  = $urandom_range(0, 10);
                end
                if ($urandom_range(0, 1))
                    pay_word[31] = 1'b1;
                build_frame(type_nib, flags, sess_word, sess_cnt, pay_word, pay_cnt, 0);
                queue_frame(0);
            end else if (pick < 95) begin
                // any type byte, mostly unknown ones
                frame_buf.delete();
                frame_buf.push_back(eed_pkg::VERSION_BYTE);
                add_random($urandom_range(3, 11));
                queue_frame(0);
            end else begin
                frame_buf.delete();
                add_random($urandom_range(1, 12));
                queue_frame(0);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || i_in_valid)
            @(posedge i_clk);
        drain = 0;
        while (predicted_results.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain = drain + 1;
        end
        repeat (20) @(posedge i_clk);

        if (predicted_results.size() != 0)
            $display("%0d expected results never arrived", predicted_results.size());
        if (mismatch_cnt == 0 && predicted_results.size() == 0) begin
            $display("event_envelope_deframer: match");
        end else begin
            $display("event_envelope_deframer: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("event_envelope_deframer: mismatch");
        $finish;
    end

endmodule
